/* rtl/core/cspt_pkg.sv */
// ----------------------------------------------------------------------------
// cspt_pkg
// Shared types and codes for the connection slot probe table.
// ----------------------------------------------------------------------------
package cspt_pkg;

  localparam int SLOT_COUNT_DEF = 1024;

  localparam int ACT_W      = 2;
  localparam int KEY_W      = 31;
  localparam int SLOT_W     = 10;
  localparam int STAT_W     = 2;

  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STORE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FREE   = 2'd2;

  localparam logic [STAT_W-1:0] ST_MATCH = 2'd0;
  localparam logic [STAT_W-1:0] ST_FREE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_WRITE = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot_in;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_PRIME,
    S_PROBE,
    S_DONE
  } state_t;

endpackage

/* rtl/core/cspt_owner_ram.sv */
// ----------------------------------------------------------------------------
// cspt_owner_ram
// Slot owner store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cspt_owner_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 31
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/cspt_home_div.sv */
// ----------------------------------------------------------------------------
// cspt_home_div
// Home slot unit: key modulo slot count by reciprocal multiplication, registered in key_q, prod, quot_slots, rem.
// ----------------------------------------------------------------------------
module cspt_home_div
  import cspt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int IDX_W      = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output logic [IDX_W-1:0] rem
);

  localparam int PROD_W = 2 * KEY_W;
  // floor(2^31 / slot count): the estimated quotient is exact or one short
  localparam logic [KEY_W-1:0] RECIP  = KEY_W'((64'd1 << KEY_W) / SLOT_COUNT);
  localparam logic [KEY_W-1:0] SLOT_K = KEY_W'(SLOT_COUNT);

  logic [2:0]        stage;
  logic [KEY_W-1:0]  key_q;
  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  quot;
  logic [KEY_W-1:0]  quot_slots;
  logic [KEY_W-1:0]  diff;
  logic [IDX_W-1:0]  rem_next;

  assign quot = prod[PROD_W-1:KEY_W];
  assign diff = key_q - quot_slots;

  // the first remainder lies below twice the slot count: one subtract settles it
  always_comb begin
    if (diff >= SLOT_K) begin
      rem_next = IDX_W'(diff - SLOT_K);
    end else begin
      rem_next = IDX_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[1:0], start};
      done  <= stage[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_q <= key;
    end
    if (stage[0]) begin
      prod <= PROD_W'(key_q) * PROD_W'(RECIP);
    end
    if (stage[1]) begin
      quot_slots <= quot * SLOT_K;
    end
    if (stage[2]) begin
      rem <= rem_next;
    end
  end

endmodule

/* rtl/core/connection_slot_probe_table_unit.sv */
// Lookup: a lookup passes the home slot unit and S_PRIME, then probes k slots (k from 1 to
//   SLOT_COUNT) before S_DONE; store, free and other actions go straight to S_DONE.
// Flow: one item at a time; a new transfer is taken only in S_IDLE. A lookup uses the home
//   slot unit and then probes slots through the single owner RAM read port.
// Reset: synchronous; afterwards a clearing pass writes zero to every slot, during which no
//   input transfer is taken.
// ----------------------------------------------------------------------------
// connection_slot_probe_table_unit
// Linear-probing table of connection slots with lookup, store and free.
// ----------------------------------------------------------------------------
module connection_slot_probe_table_unit
  import cspt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CMP_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  state_t state;
  state_t state_next;

  // Input item held for the whole search
  in_item_t item_q;

  // Probe addressing: issue_idx feeds the RAM read port, check_idx names the slot
  // whose owner is on rd_data this cycle. issue_idx also sweeps the clearing pass.
  logic [IDX_W-1:0] issue_idx;
  logic [IDX_W-1:0] issue_inc;
  logic [IDX_W-1:0] check_idx;
  logic [IDX_W-1:0] probe_cnt;

  logic [SLOT_W-1:0] res_slot;
  logic [STAT_W-1:0] res_status;

  logic             accept;
  logic             is_lookup;
  logic             in_range;
  logic             div_start;
  logic             div_done;
  logic [IDX_W-1:0] div_rem;

  logic             ram_we;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [KEY_W-1:0] ram_wr_data;
  logic [KEY_W-1:0] rd_data;

  logic hit_match;
  logic hit_free;
  logic all_probed;
  logic res_load;

  // Home slot remainder unit
  cspt_home_div #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_home_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .key   (in_data.key),
    .done  (div_done),
    .rem   (div_rem)
  );

  // Slot owner store
  cspt_owner_ram #(
    .DEPTH  (SLOT_COUNT),
    .ADDR_W (IDX_W),
    .DATA_W (KEY_W)
  ) u_owner_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (issue_idx),
    .rd_data (rd_data)
  );

  // Advance a slot index with wraparound
  assign issue_inc = (issue_idx == LAST_IDX) ? '0 : issue_idx + 1'b1;

  // Probe tests: a key match wins over a free slot; zero keys never match
  assign hit_match  = (rd_data == item_q.key) && (item_q.key != '0);
  assign hit_free   = (rd_data == '0);
  assign all_probed = (probe_cnt == LAST_IDX);

  assign is_lookup = (in_data.action == ACT_LOOKUP);
  assign in_range  = CMP_W'(in_data.slot_in) < CMP_W'(SLOT_COUNT);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (issue_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = is_lookup ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_PRIME;
        end
      end
      S_PRIME: begin
        state_next = S_PROBE;
      end
      S_PROBE: begin
        if (hit_match || hit_free || all_probed) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready    = 1'b0;
    div_start   = 1'b0;
    ram_we      = 1'b0;
    ram_wr_addr = issue_idx;
    ram_wr_data = '0;
    res_load    = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid && is_lookup;
        // store and free write in the transfer cycle; out-of-range slots change nothing
        if (in_valid && in_range &&
            (in_data.action == ACT_STORE || in_data.action == ACT_FREE)) begin
          ram_we      = 1'b1;
          ram_wr_addr = IDX_W'(in_data.slot_in);
          ram_wr_data = (in_data.action == ACT_STORE) ? in_data.key : '0;
        end
      end
      S_DONE: begin
        res_load = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      issue_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: issue_idx <= issue_inc;
        S_DIV: begin
          if (div_done) begin
            issue_idx <= div_rem;
          end
        end
        S_PRIME: issue_idx <= issue_inc;
        S_PROBE: begin
          if (!(hit_match || hit_free || all_probed)) begin
            issue_idx <= issue_inc;
          end
        end
        default: begin
        end
      endcase
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= in_data;
      if (!is_lookup) begin
        res_slot   <= in_data.slot_in;
        res_status <= ST_WRITE;
      end
    end
    if (state == S_PRIME) begin
      check_idx <= issue_idx;
      probe_cnt <= '0;
    end
    if (state == S_PROBE) begin
      if (hit_match) begin
        res_slot   <= SLOT_W'(check_idx);
        res_status <= ST_MATCH;
      end else if (hit_free) begin
        res_slot   <= SLOT_W'(check_idx);
        res_status <= ST_FREE;
      end else if (all_probed) begin
        res_slot   <= item_q.slot_in;
        res_status <= ST_FULL;
      end else begin
        check_idx <= issue_idx;
        probe_cnt <= probe_cnt + 1'b1;
      end
    end
    if (res_load) begin
      out_data.slot_out <= res_slot;
      out_data.status   <= res_status;
    end
  end

`ifndef SYNTH
  // Reset always starts the clearing pass
  a_reset_clears: assert property (@(posedge clk) rst |=> state == S_CLEAR)
    else $error("clearing pass not started after reset");

  // The remainder unit only finishes while a lookup waits for it
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("remainder done outside the hashing phase");

  // The owner store is written only by the clearing pass or an accepted store or free
  a_ram_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || (accept && !is_lookup)))
    else $error("unexpected owner store write");

  // A lookup stops once every slot has been probed and then reports a full table
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && !hit_match && !hit_free && all_probed) |=>
      (state == S_DONE && res_status == ST_FULL))
    else $error("full table not reported after the last probe");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the connection slot probe table: lookups, stores,
// frees and the spare action are driven through valid/ready, every result is
// predicted from a private copy of the slot table and checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import cspt_pkg::*;

  localparam int SLOT_COUNT  = SLOT_COUNT_DEF;
  localparam int QUIET_LIMIT = 20000;
  localparam int PHASE_ITEMS = 145;    // four random phases, ~580 transfers
  localparam int POOL_SIZE   = 32;

  // The package names three actions; the fourth code does nothing but answer.
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  // Two copies of the slot table: one for planning the stimulus, one that
  // follows the transfers actually taken by the block.
  localparam int PLAN = 0;
  localparam int LIVE = 1;

  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SRC_IDLE,
    PACE_SNK_STALL,
    PACE_BOTH
  } pace_t;

  typedef struct {
    in_item_t item;
    pace_t    pace;
    bit       drain;  // hold this transfer until every result is back
  } request_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic [KEY_W-1:0] owner_copy [2][SLOT_COUNT];
  logic [KEY_W-1:0] conn_keys [POOL_SIZE];

  request_t  request_q[$];
  out_item_t awaited_results[$];
  pace_t     cur_pace = PACE_FULL;
  int        total_reqs;
  int        accepted_n;
  int        result_n;
  int        fault_n;
  int        quiet_n;

  always #6 clk = ~clk;

  connection_slot_probe_table_unit #(
    .SLOT_COUNT(SLOT_COUNT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Apply one transfer to a table copy and return the answer it earns.
  // A lookup walks upward from the home slot with wraparound; at each slot a
  // matching owner wins over a free slot, and a zero key never matches.
  function automatic out_item_t probe_or_write(input int t, input in_item_t it);
    out_item_t   r;
    int unsigned idx;
    r.slot_out = it.slot_in;
    r.status   = ST_WRITE;
    case (it.action)
      ACT_LOOKUP: begin
        r.status = ST_FULL;
        idx = it.key % SLOT_COUNT;
        for (int n = 0; n < SLOT_COUNT; n++) begin
          if (owner_copy[t][idx] == it.key && it.key != '0) begin
            r.slot_out = idx[SLOT_W-1:0];
            r.status   = ST_MATCH;
            break;
          end
          if (owner_copy[t][idx] == '0) begin
            r.slot_out = idx[SLOT_W-1:0];
            r.status   = ST_FREE;
            break;
          end
          idx = (idx + 1) % SLOT_COUNT;
        end
      end
      ACT_STORE: begin
        if (it.slot_in < SLOT_COUNT) owner_copy[t][it.slot_in] = it.key;
      end
      ACT_FREE: begin
        if (it.slot_in < SLOT_COUNT) owner_copy[t][it.slot_in] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Queue one request and return what the planning copy says it will answer.
  function automatic out_item_t queue_request(input logic [ACT_W-1:0] act,
                                              input logic [KEY_W-1:0] key,
                                              input logic [SLOT_W-1:0] slot,
                                              input pace_t pace, input bit drain);
    request_t r;
    r.item.action  = act;
    r.item.key     = key;
    r.item.slot_in = slot;
    r.pace         = pace;
    r.drain        = drain;
    request_q.push_back(r);
    return probe_or_write(PLAN, r.item);
  endfunction

  function automatic logic [KEY_W-1:0] any_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    if (k == '0) k = KEY_W'(1);
    return k;
  endfunction

  function automatic logic [SLOT_W-1:0] any_slot();
    return SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
  endfunction

  // Decide whether a side sits out this cycle under the current pace.
  function automatic bit holds_back(input pace_t p, input bit sink);
    int pct;
    pct = 0;
    if (p == PACE_BOTH) pct = 29;
    else if (p == (sink ? PACE_SNK_STALL : PACE_SRC_IDLE)) pct = 70;
    return $urandom_range(0, 99) < pct;
  endfunction

  // Driver: take the transfer, update the live table, then present the next
  // request unless it must wait for a drain or the pace calls for a gap.
  always @(posedge clk) begin
    request_t head;
    bit       hold;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid;
      if (in_valid && in_ready) begin
        awaited_results.push_back(probe_or_write(LIVE, in_data));
        accepted_n++;
        hold = 1'b0;
      end
      if (!hold) begin
        if (request_q.size() != 0 &&
            !(request_q[0].drain && awaited_results.size() != 0) &&
            !holds_back(request_q[0].pace, 1'b0)) begin
          head = request_q.pop_front();
          in_data  <= head.item;
          in_valid <= 1'b1;
          cur_pace <= head.pace;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest awaited one, field by
  // field, and stall the result side as the pace asks.
  always @(posedge clk) begin
    out_item_t want;
    bit        bad;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        result_n++;
        bad  = 1'b1;
        want = '0;
        if (awaited_results.size() != 0) begin
          want = awaited_results.pop_front();
          bad  = out_data.slot_out !== want.slot_out || out_data.status !== want.status;
        end else begin
          want.status = 'x;
        end
        if (bad) begin
          fault_n++;
          if (fault_n <= 10)
            $display("result %0d: slot_out exp %0d got %0d, status exp %0d got %0d%s",
                     result_n, want.slot_out, out_data.slot_out, want.status,
                     out_data.status, $isunknown(want.status) ? " (none awaited)" : "");
        end
      end
      out_ready <= !holds_back(cur_pace, 1'b1);
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_n <= 0;
    end else if (quiet_n == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_n <= quiet_n + 1;
    end
  end

  initial begin
    out_item_t        plan_r;
    logic [KEY_W-1:0] k;
    int unsigned      home;
    int               mark;
    int               pick;

    for (int s = 0; s < SLOT_COUNT; s++) begin
      owner_copy[PLAN][s] = '0;
      owner_copy[LIVE][s] = '0;
    end

    // Build a pool of connection keys: clusters around the wrap point and
    // around one mid-table home, so probe chains form and cross slot zero.
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < 8)       home = (SLOT_COUNT - 3 + $urandom_range(0, 4)) % SLOT_COUNT;
      else if (i < 16) home = 300 + $urandom_range(0, 3);
      else             home = $urandom_range(0, SLOT_COUNT - 1);
      conn_keys[i] = KEY_W'($urandom_range(1, (1 << 21) - 1) * SLOT_COUNT + home);
    end

    // Directed: wraparound probing, free slot ahead of a match, zero keys,
    // the spare action and the extremes of every field.
    void'(queue_request(ACT_LOOKUP, 31'd1, '0, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_LOOKUP, '1, '0, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_STORE, '1, '1, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_LOOKUP, 31'd2047, '0, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_STORE, 31'd2047, '0, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_LOOKUP, 31'd2047, '1, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_LOOKUP, '0, '0, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_STORE, 31'd5, 10'd6, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_LOOKUP, 31'd5, '0, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_STORE, 31'd1029, 10'd5, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_LOOKUP, 31'd5, '0, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_FREE, '1, 10'd5, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_LOOKUP, 31'd5, '0, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_STORE, '0, '0, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_LOOKUP, 31'd2047, '0, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_SPARE, '1, '1, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_SPARE, '0, '0, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_FREE, '0, '1, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_LOOKUP, '1, '0, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_LOOKUP, '0, '1, PACE_BOTH, 1'b0));
    void'(queue_request(ACT_FREE, 31'd5, 10'd6, PACE_BOTH, 1'b0));

    // Random phases, one per pace. Most traffic is connect and disconnect
    // sequences on pooled keys; the rest is noise. Each phase opens with a
    // drain so the sender pauses until every result is home.
    for (int p = 0; p < 4; p++) begin
      mark = request_q.size();
      while (request_q.size() - mark < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        k    = conn_keys[$urandom_range(0, POOL_SIZE - 1)];
        if (pick < 45) begin
          // Connect: find the key's slot and usually claim it when free.
          plan_r = queue_request(ACT_LOOKUP, k, any_slot(), pace_t'(p),
                                 request_q.size() == mark);
          if (plan_r.status == ST_FREE && $urandom_range(0, 99) < 85)
            void'(queue_request(ACT_STORE, k, plan_r.slot_out, pace_t'(p), 1'b0));
        end else if (pick < 75) begin
          // Disconnect: find the key and release its slot.
          plan_r = queue_request(ACT_LOOKUP, k, any_slot(), pace_t'(p),
                                 request_q.size() == mark);
          if (plan_r.status == ST_MATCH)
            void'(queue_request(ACT_FREE, any_key(), plan_r.slot_out, pace_t'(p), 1'b0));
        end else if (pick < 85) begin
          k = ($urandom_range(0, 9) == 0) ? '0 : any_key();
          void'(queue_request(ACT_STORE, k, any_slot(), pace_t'(p),
                              request_q.size() == mark));
        end else if (pick < 92) begin
          void'(queue_request(ACT_FREE, any_key(), any_slot(), pace_t'(p),
                              request_q.size() == mark));
        end else if (pick < 96) begin
          void'(queue_request(ACT_SPARE, KEY_W'($urandom), any_slot(), pace_t'(p),
                              request_q.size() == mark));
        end else begin
          k = ($urandom_range(0, 3) == 0) ? '0 : any_key();
          void'(queue_request(ACT_LOOKUP, k, any_slot(), pace_t'(p),
                              request_q.size() == mark));
        end
      end
    end
    total_reqs = request_q.size();

    // Hold reset, then release it for good.
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait for every transfer to be taken and every result to come back,
    // then idle a little longer to catch any stray result.
    do @(negedge clk);
    while (accepted_n != total_reqs || awaited_results.size() != 0);
    repeat (60) @(posedge clk);

    if (fault_n == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
